>>> design/u8d_pkg.sv
// Package for the UTF-8 stream decoder.
// Holds the outcome codes, the result record and the byte masks.
// No dependencies.
`default_nettype none

package u8d_pkg;

	typedef enum logic [1:0] {
		OUT_READY = 2'd0,
		OUT_NONE  = 2'd1,
		OUT_ERROR = 2'd2
	} outcome_t;

	localparam int unsigned CpWidth      = 21;
	localparam int unsigned PartialWidth = 15;

	localparam logic [7:0] ContMask  = 8'h3F;
	localparam logic [7:0] Lead2Mask = 8'h1F;
	localparam logic [7:0] Lead3Mask = 8'h0F;
	localparam logic [7:0] Lead4Mask = 8'h07;

	typedef struct packed {
		outcome_t             outcome;
		logic [CpWidth-1:0]   code_point;
		logic                 idle;
	} result_t;

endpackage

`default_nettype wire

>>> design/u8d_core.sv
// Decode logic and sequence state of the UTF-8 stream decoder.
// Depends on u8d_pkg for the outcome codes, masks and result record.
`default_nettype none

module u8d_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [7:0]      byte_in,
	output u8d_pkg::result_t     res
);
	import u8d_pkg::*;

	logic [1:0]              pending_q;
	logic [PartialWidth-1:0] partial_q;
	logic [1:0]              pending_d;
	logic [PartialWidth-1:0] partial_d;
	logic [CpWidth-1:0]      joined;

	assign joined = {partial_q, byte_in[5:0]};

	always_comb begin
		pending_d      = pending_q;
		partial_d      = partial_q;
		res.outcome    = OUT_ERROR;
		res.code_point = '0;
		if (!byte_in[7]) begin
			// ASCII is only legal between sequences.
			if (pending_q == 2'd0) begin
				res.outcome    = OUT_READY;
				res.code_point = {{(CpWidth-8){1'b0}}, byte_in};
			end
		end else if (byte_in[6] == 1'b0) begin
			// Continuation byte: shift in six more bits.
			if (pending_q != 2'd0) begin
				pending_d = pending_q - 2'd1;
				if (pending_q == 2'd1) begin
					res.outcome    = OUT_READY;
					res.code_point = joined;
				end else begin
					res.outcome = OUT_NONE;
					partial_d   = joined[PartialWidth-1:0];
				end
			end
		end else if (pending_q == 2'd0) begin
			// Lead byte: keep its payload bits.
			if (!byte_in[5]) begin
				pending_d   = 2'd1;
				partial_d   = {{(PartialWidth-8){1'b0}}, byte_in & Lead2Mask};
				res.outcome = OUT_NONE;
			end else if (!byte_in[4]) begin
				pending_d   = 2'd2;
				partial_d   = {{(PartialWidth-8){1'b0}}, byte_in & Lead3Mask};
				res.outcome = OUT_NONE;
			end else if (!byte_in[3]) begin
				pending_d   = 2'd3;
				partial_d   = {{(PartialWidth-8){1'b0}}, byte_in & Lead4Mask};
				res.outcome = OUT_NONE;
			end
		end
		res.idle = (pending_d == 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			partial_q <= '0;
		end else if (step) begin
			pending_q <= pending_d;
			partial_q <= partial_d;
		end
	end

endmodule

`default_nettype wire

>>> design/utf8_stream_decoder.sv
// UTF-8 stream decoder, one byte in and one result out per transfer.
// The result is held in the input register and then in the result register before it is valid.
// Throughput: one byte per cycle unless out_ready stalls the result register; the only loop
// is the pending count and partial code point, updated by the decode logic.
// Reset clears both pipeline stages and the sequence state; a reset starts a new stream.
// Depends on u8d_pkg and u8d_core.
`default_nettype none

module utf8_stream_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       outcome,
	output logic [20:0]      code_point,
	output logic             idle
);
	import u8d_pkg::*;

	// Input register stage.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	// Result register stage.
	logic        valid_s2;
	result_t     res_s2;

	result_t     res_comb;
	logic        advance;

	// The byte in the input register moves on whenever the result register is
	// empty or its result is being taken in this cycle. Only then does the
	// sequence state change, so a stalled byte is decoded exactly once.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	u8d_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_in (byte_s1),
		.res     (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid  = valid_s2;
	assign outcome    = res_s2.outcome;
	assign code_point = res_s2.code_point;
	assign idle       = res_s2.idle;

endmodule

`default_nettype wire
